[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a synchronous active-low reset as the disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

[hw/rtl/sfp_pkg.sv]
package sfp_pkg;

    localparam int ANGLE_W              = 32;
    localparam int SINE_W               = 32;
    localparam int ANGLE_FRAC_BITS_DEF  = 20;
    localparam int RESULT_FRAC_BITS_DEF = 30;

    // 1/pi in Q32 and pi in Q60, pi split into two 31-bit halves
    localparam logic [30:0] INVPI_Q32 = 31'h517C_C1B7;
    localparam logic [63:0] PI_Q60    = 64'h3243_F6A8_885A_308D;
    localparam int          PI_SPLIT  = 31;
    localparam logic [30:0] PI_LO     = PI_Q60[30:0];
    localparam logic [30:0] PI_HI     = PI_Q60[61:31];

    // Reduced angle magnitude in Q31, squared angle, polynomial value
    localparam int F_W  = 32;
    localparam int Z_W  = 34;
    localparam int P_W  = 34;
    localparam int PM_W = 32;
    localparam int MP_W = Z_W + P_W;
    localparam int S_W  = 33;

    localparam int HORNER_STEPS = 4;

    typedef logic signed [P_W-1:0] t_coef;

    localparam t_coef C9 = 34'sd5588;
    localparam t_coef HORNER_C [HORNER_STEPS] = '{
        -34'sd425361,
        34'sd17895036,
        -34'sd357913728,
        34'sd2147483648
    };

    typedef struct packed {
        logic vld;
        logic neg;
    } t_ctrl;

    localparam int RED_STAGES  = 7;
    localparam int POLY_STAGES = 2 * (HORNER_STEPS + 1);
    localparam int RND_STAGES  = 2;
    localparam int LATENCY     = RED_STAGES + POLY_STAGES + RND_STAGES;

endpackage

[hw/rtl/sfp_reduce.sv]
module sfp_reduce #(
    parameter int ANGLE_FRAC_BITS = sfp_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_vld,
    input  logic signed [sfp_pkg::ANGLE_W-1:0] i_angle,
    output sfp_pkg::t_ctrl                    o_ctrl,
    output logic [sfp_pkg::F_W-1:0]           o_f
);

    localparam int N_W     = sfp_pkg::ANGLE_W - ANGLE_FRAC_BITS;
    localparam int PP_W    = N_W + sfp_pkg::PI_SPLIT;
    localparam int RND_POS = ANGLE_FRAC_BITS + 31;
    localparam int M_SH    = 60 - ANGLE_FRAC_BITS;
    localparam int ST      = sfp_pkg::RED_STAGES;

    logic [ST-1:0] r_vld;

    logic [31:0]     r1_mag;
    logic            r1_sgn;
    logic [62:0]     r2_prod;
    logic [31:0]     r2_mag;
    logic            r2_sgn;
    logic [N_W-1:0]  r3_quo;
    logic [31:0]     r3_mag;
    logic            r3_flip;
    logic [PP_W-1:0] r4_pphi;
    logic [PP_W-1:0] r4_pplo;
    logic [31:0]     r4_mag;
    logic            r4_flip;
    logic [63:0]     r5_pp;
    logic [63:0]     r5_msh;
    logic            r5_flip;
    logic [63:0]     r6_fabs;
    logic            r6_neg;
    logic [sfp_pkg::F_W-1:0] r7_f;
    logic            r7_neg;

    logic [31:0]     n_mag;
    logic [62:0]     n_prod;
    logic [63:0]     n_rnd;
    logic [N_W-1:0]  n_quo;
    logic [PP_W-1:0] n_pphi;
    logic [PP_W-1:0] n_pplo;
    logic [63:0]     n_pp;
    logic [63:0]     n_msh;
    logic [63:0]     n_dpos;
    logic [63:0]     n_dneg;
    logic            n_fneg;
    logic [63:0]     n_fsum;

    always_comb begin
        n_mag  = i_angle[sfp_pkg::ANGLE_W-1] ? 32'(-i_angle) : 32'(i_angle);
        n_prod = 63'(r1_mag) * 63'(sfp_pkg::INVPI_Q32);
        n_rnd  = {1'b0, r2_prod} + (64'd1 << RND_POS);
        n_quo  = n_rnd[63 -: N_W];
        n_pphi = PP_W'(r3_quo) * PP_W'(sfp_pkg::PI_HI);
        n_pplo = PP_W'(r3_quo) * PP_W'(sfp_pkg::PI_LO);
        n_pp   = (64'(r4_pphi) << sfp_pkg::PI_SPLIT) + 64'(r4_pplo);
        n_msh  = 64'(r4_mag) << M_SH;
        n_dpos = r5_msh - r5_pp;
        n_dneg = r5_pp - r5_msh;
        n_fneg = n_dpos[63];
        n_fsum = r6_fabs + (64'd1 << 28);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[ST-2:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_mag  <= n_mag;
        r1_sgn  <= i_angle[sfp_pkg::ANGLE_W-1];
        r2_prod <= n_prod;
        r2_mag  <= r1_mag;
        r2_sgn  <= r1_sgn;
        r3_quo  <= n_quo;
        r3_mag  <= r2_mag;
        r3_flip <= r2_sgn ^ n_quo[0];
        r4_pphi <= n_pphi;
        r4_pplo <= n_pplo;
        r4_mag  <= r3_mag;
        r4_flip <= r3_flip;
        r5_pp   <= n_pp;
        r5_msh  <= n_msh;
        r5_flip <= r4_flip;
        r6_fabs <= n_fneg ? n_dneg : n_dpos;
        r6_neg  <= r5_flip ^ n_fneg;
        r7_f    <= n_fsum[60:29];
        r7_neg  <= r6_neg;
    end

    assign o_ctrl = '{vld: r_vld[ST-1], neg: r7_neg};
    assign o_f    = r7_f;

endmodule

[hw/rtl/sfp_poly.sv]
module sfp_poly (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sfp_pkg::t_ctrl          i_ctrl,
    input  logic [sfp_pkg::F_W-1:0] i_f,
    output sfp_pkg::t_ctrl          o_ctrl,
    output logic [sfp_pkg::S_W-1:0] o_s
);

    localparam int HS   = sfp_pkg::HORNER_STEPS;
    localparam int F_W  = sfp_pkg::F_W;
    localparam int Z_W  = sfp_pkg::Z_W;
    localparam int P_W  = sfp_pkg::P_W;
    localparam int MP_W = sfp_pkg::MP_W;
    localparam int PM_W = sfp_pkg::PM_W;

    logic [63:0]          r_sq;
    logic [F_W-1:0]       r_f0;
    sfp_pkg::t_ctrl       r_c0;

    logic signed [Z_W-1:0]  r_mz    [HS];
    logic signed [MP_W-1:0] r_mprod [HS];
    logic [F_W-1:0]         r_mf    [HS];
    sfp_pkg::t_ctrl         r_mc    [HS];
    logic signed [Z_W-1:0]  r_az    [HS];
    logic signed [P_W-1:0]  r_ap    [HS];
    logic [F_W-1:0]         r_af    [HS];
    sfp_pkg::t_ctrl         r_ac    [HS];

    logic [63:0]          r_sprod;
    sfp_pkg::t_ctrl       r_sc;

    logic signed [P_W-1:0] n_plast;
    logic [63:0]           n_sprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= '0;
        end else begin
            r_c0 <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= 64'(i_f) * 64'(i_f);
        r_f0 <= i_f;
    end

    for (genvar k = 0; k < HS; k++) begin : g_step
        logic signed [Z_W-1:0]  z_in;
        logic signed [P_W-1:0]  p_in;
        logic [F_W-1:0]         f_in;
        sfp_pkg::t_ctrl         c_in;
        logic signed [MP_W-1:0] n_mprod;
        logic signed [P_W-1:0]  n_ap;

        if (k == 0) begin : g_first
            assign z_in = $signed({1'b0, r_sq[63:31]});
            assign p_in = sfp_pkg::C9;
            assign f_in = r_f0;
            assign c_in = r_c0;
        end else begin : g_next
            assign z_in = r_az[k-1];
            assign p_in = r_ap[k-1];
            assign f_in = r_af[k-1];
            assign c_in = r_ac[k-1];
        end

        assign n_mprod = z_in * p_in;
        assign n_ap    = sfp_pkg::HORNER_C[k] + $signed(r_mprod[k][P_W+30:31]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mc[k] <= '0;
                r_ac[k] <= '0;
            end else begin
                r_mc[k] <= c_in;
                r_ac[k] <= r_mc[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_mz[k]    <= z_in;
            r_mprod[k] <= n_mprod;
            r_mf[k]    <= f_in;
            r_az[k]    <= r_mz[k];
            r_ap[k]    <= n_ap;
            r_af[k]    <= r_mf[k];
        end
    end

    always_comb begin
        n_plast = r_ap[HS-1];
        if (n_plast[P_W-1]) begin
            n_sprod = '0;
        end else begin
            n_sprod = 64'(r_af[HS-1]) * 64'(n_plast[PM_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc <= '0;
        end else begin
            r_sc <= r_ac[HS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sprod <= n_sprod;
    end

    assign o_ctrl = r_sc;
    assign o_s    = r_sprod[63:31];

endmodule

[hw/rtl/sfp_round.sv]
module sfp_round #(
    parameter int RESULT_FRAC_BITS = sfp_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sfp_pkg::t_ctrl                      i_ctrl,
    input  logic [sfp_pkg::S_W-1:0]             i_s,
    output logic                                o_valid,
    output logic signed [sfp_pkg::SINE_W-1:0]   o_sine
);

    localparam int SINE_W = sfp_pkg::SINE_W;
    localparam int SUM_W  = sfp_pkg::S_W + 1;
    localparam int R_SH   = 31 - RESULT_FRAC_BITS;
    localparam int R_W    = SUM_W - R_SH;
    localparam logic [R_W-1:0] ONE = R_W'(1) << RESULT_FRAC_BITS;

    logic [R_W-1:0]             r_r;
    sfp_pkg::t_ctrl             r_c1;
    logic                       r_vld;
    logic signed [SINE_W-1:0]   r_sine;

    logic [SUM_W-1:0]           n_rsum;
    logic [R_W-1:0]             n_mag;
    logic signed [SINE_W-1:0]   n_ext;
    logic signed [SINE_W-1:0]   n_sine;

    always_comb begin
        n_rsum = SUM_W'(i_s) + (SUM_W'(1) << (30 - RESULT_FRAC_BITS));
        n_mag  = (r_r > ONE) ? ONE : r_r;
        n_ext  = $signed(SINE_W'(n_mag));
        n_sine = r_c1.neg ? -n_ext : n_ext;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1  <= '0;
            r_vld <= 1'b0;
        end else begin
            r_c1  <= i_ctrl;
            r_vld <= r_c1.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r    <= n_rsum[SUM_W-1:R_SH];
        r_sine <= n_sine;
    end

    assign o_valid = r_vld;
    assign o_sine  = r_sine;

endmodule

[hw/rtl/sine_fixed_point_poly_top.sv]
// Channel   Direction  Transfer               Payload
// command   in         start high, busy low   i_angle  (Q11.20 radians, signed)
// result    out        o_valid, one cycle     o_sine   (Q1.30, signed)
//
// A new angle may enter on every cycle; each result follows its command
// transfer, in command order. The pipeline has 7 stages of range reduction,
// 10 of Horner evaluation, 2 of rounding.
// i_rst_n is synchronous and clears the valid bits of every stage.
// busy is high only while reset is held; results cannot be stalled.
module sine_fixed_point_poly_top #(
    parameter int ANGLE_FRAC_BITS  = sfp_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int RESULT_FRAC_BITS = sfp_pkg::RESULT_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [sfp_pkg::ANGLE_W-1:0]  i_angle,
    output logic                                o_valid,
    output logic signed [sfp_pkg::SINE_W-1:0]   o_sine
);

    sfp_pkg::t_ctrl             red_ctrl;
    logic [sfp_pkg::F_W-1:0]    red_f;
    sfp_pkg::t_ctrl             poly_ctrl;
    logic [sfp_pkg::S_W-1:0]    poly_s;

    assign busy = ~i_rst_n;

    sfp_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_angle (i_angle),
        .o_ctrl  (red_ctrl),
        .o_f     (red_f)
    );

    sfp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (red_ctrl),
        .i_f     (red_f),
        .o_ctrl  (poly_ctrl),
        .o_s     (poly_s)
    );

    sfp_round #(
        .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
    ) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (poly_ctrl),
        .i_s     (poly_s),
        .o_valid (o_valid),
        .o_sine  (o_sine)
    );

endmodule

[hw/rtl/sfp_checker.sv]
`include "assert_macros.svh"

module sfp_checker #(
    parameter int RESULT_FRAC_BITS = sfp_pkg::RESULT_FRAC_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [sfp_pkg::ANGLE_W-1:0]  i_angle,
    input logic                                o_valid,
    input logic signed [sfp_pkg::SINE_W-1:0]   o_sine
);

    localparam int LAT = sfp_pkg::LATENCY;
    localparam logic signed [sfp_pkg::SINE_W-1:0] ONE =
        sfp_pkg::SINE_W'(64'sd1 <<< RESULT_FRAC_BITS);

    `ASSERT_CLK(a_result_follows, i_clk, i_rst_n, (start && !busy) |-> ##LAT o_valid, "result missing after transfer")
    `ASSERT_CLK(a_no_stray_result, i_clk, i_rst_n, !(start && !busy) |-> ##LAT !o_valid, "result without transfer")
    `ASSERT_CLK(a_zero_angle, i_clk, i_rst_n, (start && !busy && i_angle == 32'sd0) |-> ##LAT (o_sine == 32'sd0), "zero angle gave nonzero sine")
    `ASSERT_NEVER(a_saturated, i_clk, i_rst_n, o_valid && (o_sine > ONE || o_sine < -ONE), "sine beyond unit range")

endmodule

bind sine_fixed_point_poly_top sfp_checker #(
    .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_sfp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_angle (i_angle),
    .o_valid (o_valid),
    .o_sine  (o_sine)
);
